// ----- hw/rtl/column_pattern_dedup_assert.svh -----
// Assertion macros for the column pattern dedup block.
// Expects clk and rst_n in the scope of each use.
`ifndef COLUMN_PATTERN_DEDUP_ASSERT_SVH
`define COLUMN_PATTERN_DEDUP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CPD_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cpd_pkg.sv -----
// Shared constants for the column pattern dedup block.
// No dependencies.
`timescale 1ns / 1ps

package cpd_pkg;

  // Item field widths
  localparam int SYM_W = 8;
  localparam int IDX_W = 10;
  localparam int TOT_W = 11;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam int NUM_TAXA_W = 7;
  localparam logic [CFG_AW-1:0] ADDR_NUM_TAXA = 3'd0;
  localparam logic [NUM_TAXA_W-1:0] NUM_TAXA_RST = 7'd4;

  // Byte lane of a stored pattern row
  localparam int LANE_W = 8;

endpackage

// ----- hw/rtl/column_pattern_dedup.sv -----
// Column pattern dedup top level: symbol intake, pattern search, result register.
// Depends on cpd_pkg, cpd_ram and column_pattern_dedup_assert.svh.
// Timing: a symbol that does not close a column is stored in the column register. A closing symbol
// within site capacity starts a search over the pattern RAM, one stored row per cycle, until a
// hit or a new pattern is found; intake is held until the result is registered for output.
// Reset (rst_n, synchronous) clears counters and state, sets num_taxa to 4; RAM is kept.
`timescale 1ns / 1ps
`include "column_pattern_dedup_assert.svh"

module column_pattern_dedup #(
  parameter int MAX_TAXA  = 64,
  parameter int MAX_SITES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // symbol intake
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cpd_pkg::SYM_W-1:0]          in_symbol,
  input  logic                               in_new_alignment,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cpd_pkg::IDX_W-1:0]          out_site_index,
  output logic [cpd_pkg::IDX_W-1:0]          out_pattern_index,
  output logic                               out_is_new,
  output logic [cpd_pkg::TOT_W-1:0]          out_pattern_total,
  output logic                               out_overflow,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cpd_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [cpd_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [cpd_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  localparam int SYM_W  = cpd_pkg::SYM_W;
  localparam int IDX_W  = cpd_pkg::IDX_W;
  localparam int TOT_W  = cpd_pkg::TOT_W;
  localparam int CFG_DW = cpd_pkg::CFG_DW;
  localparam int NT_W   = cpd_pkg::NUM_TAXA_W;
  localparam int TC_W   = $clog2(MAX_TAXA);
  localparam int TX_W   = $clog2(MAX_TAXA + 1);
  localparam int PI_W   = $clog2(MAX_SITES);
  localparam int CNT_W  = $clog2(MAX_SITES + 1);
  localparam int ROW_W  = SYM_W * MAX_TAXA;
  localparam int NTX_EXT_W = 9;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Registers
  logic [1:0]        state_r,    state_nxt;
  logic [NT_W-1:0]   num_taxa_r, num_taxa_nxt;
  logic [TC_W-1:0]   taxon_r,    taxon_nxt;
  logic [CNT_W-1:0]  site_r,     site_nxt;
  logic [CNT_W-1:0]  pat_cnt_r,  pat_cnt_nxt;
  logic [CNT_W-1:0]  rd_ptr_r,   rd_ptr_nxt;
  logic              cmp_vld_r,  cmp_vld_nxt;
  logic [PI_W-1:0]   cmp_idx_r,  cmp_idx_nxt;
  logic [IDX_W-1:0]  pend_site_r, pend_site_nxt;
  logic [IDX_W-1:0]  pend_pat_r,  pend_pat_nxt;
  logic              pend_new_r,  pend_new_nxt;
  logic              pend_ovf_r,  pend_ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_site_r,  out_site_nxt;
  logic [IDX_W-1:0]  out_pat_r,   out_pat_nxt;
  logic              out_new_r,   out_new_nxt;
  logic [TOT_W-1:0]  out_total_r, out_total_nxt;
  logic              out_ovf_r,   out_ovf_nxt;
  logic [SYM_W-1:0]  col_r [MAX_TAXA];

  // Combinational
  logic                 in_acc, out_free, cfg_wr;
  logic [TX_W-1:0]      taxa_eff;
  logic [NTX_EXT_W-1:0] ntx_ext;
  logic [MAX_TAXA-1:0]  lane_mask, lane_hit;
  logic [ROW_W-1:0]     col_row;
  logic [TC_W-1:0]      taxon_eff;
  logic [CNT_W-1:0]     site_eff, cnt_eff;
  logic                 col_done, hit, cmp_last, no_hit_end, store_full;
  logic                 ram_we, ram_re;
  logic [PI_W-1:0]      ram_waddr, ram_raddr;
  logic [ROW_W-1:0]     ram_rdata;

  // Pattern store: one row of MAX_TAXA symbols per pattern
  cpd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SITES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_be   (lane_mask),
    .wr_addr (ram_waddr),
    .wr_data (col_row),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Handshakes
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == cpd_pkg::ADDR_NUM_TAXA);
  assign cfg_prdata = (cfg_paddr == cpd_pkg::ADDR_NUM_TAXA) ? CFG_DW'(num_taxa_r) : '0;

  // Effective taxa count: zero acts as one, clamp at MAX_TAXA
  assign ntx_ext = NTX_EXT_W'(num_taxa_r);
  always_comb begin
    if (num_taxa_r == '0) begin
      taxa_eff = TX_W'(1);
    end else if (ntx_ext > NTX_EXT_W'(MAX_TAXA)) begin
      taxa_eff = TX_W'(MAX_TAXA);
    end else begin
      taxa_eff = TX_W'(num_taxa_r);
    end
  end

  // Lane mask, column row and masked row compare
  always_comb begin
    for (int t = 0; t < MAX_TAXA; t++) begin
      lane_mask[t] = (TX_W'(t) < taxa_eff);
      col_row[SYM_W*t +: SYM_W] = col_r[t];
      lane_hit[t] = !lane_mask[t] || (ram_rdata[SYM_W*t +: SYM_W] == col_r[t]);
    end
  end

  // A new alignment clears the counters before its first symbol is taken
  assign taxon_eff = in_new_alignment ? '0 : taxon_r;
  assign site_eff  = in_new_alignment ? '0 : site_r;
  assign cnt_eff   = in_new_alignment ? '0 : pat_cnt_r;
  assign col_done  = (TX_W'(taxon_eff) + TX_W'(1)) >= taxa_eff;

  assign hit        = cmp_vld_r && (&lane_hit);
  assign cmp_last   = (CNT_W'(cmp_idx_r) + CNT_W'(1)) == pat_cnt_r;
  assign no_hit_end = (pat_cnt_r == '0) || (cmp_vld_r && !hit && cmp_last);
  assign store_full = pat_cnt_r >= CNT_W'(MAX_SITES);

  assign ram_waddr = pat_cnt_r[PI_W-1:0];
  assign ram_raddr = rd_ptr_r[PI_W-1:0];

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    num_taxa_nxt  = num_taxa_r;
    taxon_nxt     = taxon_r;
    site_nxt      = site_r;
    pat_cnt_nxt   = pat_cnt_r;
    rd_ptr_nxt    = rd_ptr_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = rd_ptr_r[PI_W-1:0];
    pend_site_nxt = pend_site_r;
    pend_pat_nxt  = pend_pat_r;
    pend_new_nxt  = pend_new_r;
    pend_ovf_nxt  = pend_ovf_r;
    out_valid_nxt = out_valid_r;
    out_site_nxt  = out_site_r;
    out_pat_nxt   = out_pat_r;
    out_new_nxt   = out_new_r;
    out_total_nxt = out_total_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (cfg_wr) begin
      num_taxa_nxt = cfg_pwdata[NT_W-1:0];
    end

    // Result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          site_nxt    = site_eff;
          pat_cnt_nxt = cnt_eff;
          if (!col_done) begin
            taxon_nxt = taxon_eff + TC_W'(1);
          end else begin
            taxon_nxt = '0;
            if (site_eff >= CNT_W'(MAX_SITES)) begin
              // site beyond capacity: no compare, no store
              pend_site_nxt = '0;
              pend_pat_nxt  = '0;
              pend_new_nxt  = 1'b0;
              pend_ovf_nxt  = 1'b1;
              site_nxt      = CNT_W'(MAX_SITES);
              state_nxt     = ST_FINISH;
            end else begin
              rd_ptr_nxt = '0;
              state_nxt  = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          pend_site_nxt = IDX_W'(site_r);
          pend_pat_nxt  = IDX_W'(cmp_idx_r);
          pend_new_nxt  = 1'b0;
          pend_ovf_nxt  = 1'b0;
          site_nxt      = site_r + CNT_W'(1);
          state_nxt     = ST_FINISH;
        end else if (no_hit_end) begin
          pend_site_nxt = IDX_W'(site_r);
          site_nxt      = site_r + CNT_W'(1);
          state_nxt     = ST_FINISH;
          if (store_full) begin
            pend_pat_nxt = '0;
            pend_new_nxt = 1'b0;
            pend_ovf_nxt = 1'b1;
          end else begin
            // append column as the next pattern
            ram_we       = 1'b1;
            pend_pat_nxt = IDX_W'(pat_cnt_r);
            pend_new_nxt = 1'b1;
            pend_ovf_nxt = 1'b0;
            pat_cnt_nxt  = pat_cnt_r + CNT_W'(1);
          end
        end else begin
          // issue the next stored row
          ram_re = (rd_ptr_r != pat_cnt_r);
          if (ram_re) begin
            rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          end
          cmp_vld_nxt = ram_re;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_site_nxt  = pend_site_r;
          out_pat_nxt   = pend_pat_r;
          out_new_nxt   = pend_new_r;
          out_ovf_nxt   = pend_ovf_r;
          out_total_nxt = TOT_W'(pat_cnt_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_taxa_r  <= cpd_pkg::NUM_TAXA_RST;
      taxon_r     <= '0;
      site_r      <= '0;
      pat_cnt_r   <= '0;
      rd_ptr_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_taxa_r  <= num_taxa_nxt;
      taxon_r     <= taxon_nxt;
      site_r      <= site_nxt;
      pat_cnt_r   <= pat_cnt_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    pend_site_r <= pend_site_nxt;
    pend_pat_r  <= pend_pat_nxt;
    pend_new_r  <= pend_new_nxt;
    pend_ovf_r  <= pend_ovf_nxt;
    out_site_r  <= out_site_nxt;
    out_pat_r   <= out_pat_nxt;
    out_new_r   <= out_new_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (in_acc) begin
      col_r[taxon_eff] <= in_symbol;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_site_index    = out_site_r;
  assign out_pattern_index = out_pat_r;
  assign out_is_new        = out_new_r;
  assign out_pattern_total = out_total_r;
  assign out_overflow      = out_ovf_r;

  // Checks
  `CPD_ASSERT_HOLD(a_no_rw_same_row, ram_we, !ram_re, "pattern RAM read and write overlap")
  `CPD_ASSERT_HOLD(a_cnt_bound, 1'b1, pat_cnt_r <= CNT_W'(MAX_SITES), "pattern count past capacity")
  `CPD_ASSERT_HOLD(a_cmp_in_search, cmp_vld_r, state_r == ST_SEARCH, "compare outside search")
  `CPD_ASSERT_NEXT(a_search_done, (state_r == ST_SEARCH) && (hit || no_hit_end), state_r == ST_FINISH, "search decision lost")
  `CPD_ASSERT_HOLD(a_new_not_ovf, out_valid_r && out_new_r, !out_ovf_r, "new pattern flagged as overflow")

endmodule

// ----- hw/rtl/cpd_ram.sv -----
// Generic simple dual-port RAM with byte-lane write enables and registered read.
// Depends on cpd_pkg for the lane width.
`timescale 1ns / 1ps

module cpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH),
  localparam int NB = WIDTH / cpd_pkg::LANE_W
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [NB-1:0]    wr_be,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  localparam int LW = cpd_pkg::LANE_W;

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Lane-masked write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < NB; b++) begin
        if (wr_be[b]) begin
          mem_q[wr_addr][LW*b +: LW] <= wr_data[LW*b +: LW];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_q[rd_addr];
    end
  end

endmodule
